// ----- rtl/core/csob_pkg.sv -----
// ----------------------------------------------------------------------------
// csob_pkg
// shared types and constants of the cursor sprite overlay blend core
// ----------------------------------------------------------------------------
package csob_pkg;

   localparam int SPRITE_DIM_DEFAULT    = 64;
   localparam int MAX_FRAME_DIM_DEFAULT = 4096;

   localparam int PIXEL_W     = 32;
   localparam int LOAD_POS_W  = 6;
   localparam int FRAME_DIM_W = 13;
   localparam int POINTER_W   = 16;
   localparam int HOT_W       = 6;
   localparam int SPRITE_SZ_W = 7;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_FRAME = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 3'd0,
      CSR_FRAME_HEIGHT = 3'd1,
      CSR_POINTER_X    = 3'd2,
      CSR_POINTER_Y    = 3'd3,
      CSR_HOT_X        = 3'd4,
      CSR_HOT_Y        = 3'd5,
      CSR_SPRITE_COLS  = 3'd6,
      CSR_SPRITE_ROWS  = 3'd7
   } csr_index_type;

endpackage

// ----- rtl/core/csob_req_if.sv -----
// ----------------------------------------------------------------------------
// csob_req_if
// request channel: sprite loads and frame pixels
// ----------------------------------------------------------------------------
interface csob_req_if
   import csob_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic                  command;
   logic [LOAD_POS_W-1:0] load_row;
   logic [LOAD_POS_W-1:0] load_col;
   logic [PIXEL_W-1:0]    pixel;

   modport source (output valid, command, load_row, load_col, pixel, input ready);
   modport sink   (input valid, command, load_row, load_col, pixel, output ready);
endinterface

// ----- rtl/core/csob_rsp_if.sv -----
// ----------------------------------------------------------------------------
// csob_rsp_if
// result channel: composited frame pixels
// ----------------------------------------------------------------------------
interface csob_rsp_if
   import csob_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] out_pixel;
   logic               covered;
   logic               frame_end;

   modport source (output valid, out_pixel, covered, frame_end, input ready);
   modport sink   (input valid, out_pixel, covered, frame_end, output ready);
endinterface

// ----- rtl/core/csob_ram.sv -----
// ----------------------------------------------------------------------------
// csob_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module csob_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/core/cursor_sprite_overlay_blend_core.sv -----
// ----------------------------------------------------------------------------
// cursor_sprite_overlay_blend_core
// pointer sprite overlay with premultiplied alpha on a raster pixel stream
// ----------------------------------------------------------------------------
// a request with command 0 writes one sprite pixel at load_row/load_col and
// gives no result; a request with command 1 is one frame pixel in raster
// order and gives exactly one result on rsp_ch. the raster position is kept
// internally and wraps at frame_width/frame_height, frame_end marks the last
// pixel of each frame. csr writes set frame size, pointer, hotspot and sprite
// size and must only be issued while the core is idle.
// pipeline: three register stages (input register with sprite ram read,
// multiply stage, divide/add into the output register) that each frame
// pixel passes through in that order before it is valid on rsp_ch.
// throughput: one request per cycle while rsp_ch is not stalled, set by
// the single ram read port and the three-stage pipeline that all advance together.
// a stalled rsp_ch holds the whole pipeline and drops req_ch.ready in the
// same cycle; nothing is lost. reset clears the raster position, registers
// and pipeline valid bits; the sprite ram is not cleared and must be loaded
// before the sprite is shown.
// ----------------------------------------------------------------------------
module cursor_sprite_overlay_blend_core
   import csob_pkg::*;
#(
   parameter int SPRITE_DIM    = SPRITE_DIM_DEFAULT,
   parameter int MAX_FRAME_DIM = MAX_FRAME_DIM_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   csob_req_if.sink              req_ch,
   csob_rsp_if.source            rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam int DEPTH = SPRITE_DIM * SPRITE_DIM;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(MAX_FRAME_DIM);
   localparam int SW    = ((CW > POINTER_W) ? CW : POINTER_W) + 4;
   localparam logic signed [SW-1:0] MAX_S = SW'(MAX_FRAME_DIM);
   localparam logic signed [SW-1:0] SD_S  = SW'(SPRITE_DIM);

   // configuration registers
   logic [FRAME_DIM_W-1:0]      frame_width_ff, frame_height_ff;
   logic signed [POINTER_W-1:0] pointer_x_ff, pointer_y_ff;
   logic [HOT_W-1:0]            hot_x_ff, hot_y_ff;
   logic [SPRITE_SZ_W-1:0]      sprite_cols_ff, sprite_rows_ff;

   logic [CW-1:0] col_ff, row_ff, col_in, row_in;

   logic advance, acc, acc_frame, acc_load;

   logic signed [SW-1:0] w_s, h_s, sc_s, sr_s, x_s, y_s, c_s, r_s;
   logic signed [SW-1:0] hx_s, hy_s, left_s, top_s, lr_s, lc_s, rd_full, wr_full;
   logic frame_on, visible, in_rect, cov_c, col_wrap, row_wrap, fend_c, load_ok;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [PIXEL_W-1:0] sprite_px;

   // pipeline
   logic               s1_valid_ff, s1_cov_ff, s1_fend_ff;
   logic [PIXEL_W-1:0] s1_dst_ff;
   logic               s2_valid_ff, s2_cov_ff, s2_fend_ff;
   logic [PIXEL_W-1:0] s2_dst_ff, s2_src_ff;
   logic [15:0]        s2_prod_ff [4];
   logic [15:0]        prod [4];
   logic [7:0]         inv_a;
   logic [PIXEL_W-1:0] blend_px;
   logic               rsp_valid_ff, rsp_cov_ff, rsp_fend_ff;
   logic [PIXEL_W-1:0] rsp_pixel_ff;

   assign advance   = !rsp_valid_ff || rsp_ch.ready;
   assign acc       = req_ch.valid && advance;
   assign acc_frame = acc && (req_ch.command == CMD_FRAME);
   assign acc_load  = acc && (req_ch.command == CMD_LOAD);
   assign req_ch.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= '0;
         frame_height_ff <= '0;
         pointer_x_ff    <= '0;
         pointer_y_ff    <= '0;
         hot_x_ff        <= '0;
         hot_y_ff        <= '0;
         sprite_cols_ff  <= '0;
         sprite_rows_ff  <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[FRAME_DIM_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[FRAME_DIM_W-1:0];
            CSR_POINTER_X:    pointer_x_ff    <= signed'(csr_wdata[POINTER_W-1:0]);
            CSR_POINTER_Y:    pointer_y_ff    <= signed'(csr_wdata[POINTER_W-1:0]);
            CSR_HOT_X:        hot_x_ff        <= csr_wdata[HOT_W-1:0];
            CSR_HOT_Y:        hot_y_ff        <= csr_wdata[HOT_W-1:0];
            CSR_SPRITE_COLS:  sprite_cols_ff  <= csr_wdata[SPRITE_SZ_W-1:0];
            CSR_SPRITE_ROWS:  sprite_rows_ff  <= csr_wdata[SPRITE_SZ_W-1:0];
            default: ;
         endcase
      end
   end

   // coverage test and sprite address for the current raster position
   always_comb begin
      w_s = signed'(SW'(frame_width_ff));
      if (w_s > MAX_S) w_s = MAX_S;
      h_s = signed'(SW'(frame_height_ff));
      if (h_s > MAX_S) h_s = MAX_S;
      sc_s = signed'(SW'(sprite_cols_ff));
      if (sc_s > SD_S) sc_s = SD_S;
      sr_s = signed'(SW'(sprite_rows_ff));
      if (sr_s > SD_S) sr_s = SD_S;
      x_s    = SW'(pointer_x_ff);
      y_s    = SW'(pointer_y_ff);
      c_s    = signed'(SW'(col_ff));
      r_s    = signed'(SW'(row_ff));
      hx_s   = signed'(SW'(hot_x_ff));
      hy_s   = signed'(SW'(hot_y_ff));
      left_s = x_s - hx_s;
      top_s  = y_s - hy_s;

      frame_on = (w_s != '0) && (h_s != '0);
      visible  = (sc_s != '0) && (sr_s != '0) && (hx_s < sc_s) && (hy_s < sr_s) &&
                 (x_s >= 0) && (y_s >= 0) && (x_s < w_s) && (y_s < h_s) &&
                 (c_s < w_s) && (r_s < h_s);
      in_rect  = (c_s >= left_s) && (c_s < left_s + sc_s) &&
                 (r_s >= top_s) && (r_s < top_s + sr_s);
      cov_c    = frame_on && visible && in_rect;
      col_wrap = c_s >= w_s - 1;
      row_wrap = r_s >= h_s - 1;
      fend_c   = frame_on && col_wrap && row_wrap;

      rd_full = (r_s - top_s) * SD_S + (c_s - left_s);
      rd_addr = AW'(unsigned'(rd_full));

      lr_s    = signed'(SW'(req_ch.load_row));
      lc_s    = signed'(SW'(req_ch.load_col));
      load_ok = (lr_s < SD_S) && (lc_s < SD_S);
      wr_full = lr_s * SD_S + lc_s;
      wr_addr = AW'(unsigned'(wr_full));

      col_in = col_ff;
      row_in = row_ff;
      if (acc_frame && frame_on) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   csob_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (DEPTH)
   ) u_sprite_ram (
      .clock   (clock),
      .wr_en   (acc_load && load_ok),
      .wr_addr (wr_addr),
      .wr_data (req_ch.pixel),
      .rd_en   (advance),
      .rd_addr (rd_addr),
      .rd_data (sprite_px)
   );

   // multiply stage
   always_comb begin
      inv_a = 8'd255 - sprite_px[31:24];
      for (int ch = 0; ch < 4; ch++) begin
         prod[ch] = s1_dst_ff[8*ch +: 8] * inv_a;
      end
   end

   // divide by 255 with rounding, add source, saturate
   always_comb begin
      logic [16:0] t;
      logic [16:0] q;
      logic [9:0]  v;
      blend_px = '0;
      for (int ch = 0; ch < 4; ch++) begin
         t = 17'(s2_prod_ff[ch]) + 17'd127;
         q = (t + (t >> 8) + 17'd1) >> 8;
         v = 10'(s2_src_ff[8*ch +: 8]) + q[9:0];
         blend_px[8*ch +: 8] = (v > 10'd255) ? 8'd255 : v[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= acc_frame;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_dst_ff    <= req_ch.pixel;
         s1_cov_ff    <= cov_c;
         s1_fend_ff   <= fend_c;
         s2_dst_ff    <= s1_dst_ff;
         s2_src_ff    <= sprite_px;
         s2_cov_ff    <= s1_cov_ff;
         s2_fend_ff   <= s1_fend_ff;
         s2_prod_ff   <= prod;
         rsp_pixel_ff <= s2_cov_ff ? blend_px : s2_dst_ff;
         rsp_cov_ff   <= s2_cov_ff;
         rsp_fend_ff  <= s2_fend_ff;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_pixel = rsp_pixel_ff;
   assign rsp_ch.covered   = rsp_cov_ff;
   assign rsp_ch.frame_end = rsp_fend_ff;

`ifndef SYNTHESIS
   a_stall_blocks_req : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |-> !req_ch.ready)
      else $error("request taken while result stalled");

   a_frame_end_wraps : assert property (@(posedge clock) disable iff (reset)
      acc_frame && fend_c |=> (col_ff == '0) && (row_ff == '0))
      else $error("raster position not cleared after last pixel");

   a_counters_hold : assert property (@(posedge clock) disable iff (reset)
      !acc_frame |=> $stable(col_ff) && $stable(row_ff))
      else $error("raster position moved without a frame pixel");

   a_cover_needs_frame : assert property (@(posedge clock) disable iff (reset)
      acc_frame && !frame_on |=> !s1_cov_ff && !s1_fend_ff)
      else $error("coverage flagged with zero frame size");
`endif
endmodule
